/* sv/lefe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lefe_pkg
// Shared codes, types and helpers of the LED effect frame engine.
// ----------------------------------------------------------------------------
package lefe_pkg;

  // Command codes carried in the mode field
  localparam logic [3:0] MODE_TICK      = 4'd0;
  localparam logic [3:0] MODE_SET_ALL   = 4'd1;
  localparam logic [3:0] MODE_SET_LED   = 4'd2;
  localparam logic [3:0] MODE_BLINK     = 4'd3;
  localparam logic [3:0] MODE_PULSE     = 4'd4;
  localparam logic [3:0] MODE_TRANS     = 4'd5;
  localparam logic [3:0] MODE_BLINK_ONE = 4'd6;
  localparam logic [3:0] MODE_PULSE_ONE = 4'd7;
  localparam logic [3:0] MODE_TRANS_ONE = 4'd8;

  // Result action codes
  localparam logic [1:0] ACT_REFRESH = 2'd0;
  localparam logic [1:0] ACT_ALL     = 2'd1;
  localparam logic [1:0] ACT_ONE     = 2'd2;

  // Divider steps: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_BLINK,
    KIND_PULSE,
    KIND_TRANS
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OUT_CMD,
    ST_MUL,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_PREP,
    ST_CH_GO,
    ST_CH_WAIT,
    ST_FIN,
    ST_OUT_FIN
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic out_cmd;
    logic out_idle;
    logic mul;
    logic mod_go;
    logic pos_load;
    logic prep;
    logic ch_go;
    logic ch_store;
    logic fin;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic  cmd_res;
    logic  frame_act;
    kind_e kind;
    logic  trans_end;
    logic  div_busy;
    logic  ch_last;
  } sts_t;

  // Pick one 8-bit channel of a color, red first
  function automatic logic [7:0] chan_sel(input logic [23:0] col, input logic [1:0] ch);
    logic [7:0] r;
    case (ch)
      2'd0:    r = col[23:16];
      2'd1:    r = col[15:8];
      default: r = col[7:0];
    endcase
    return r;
  endfunction

endpackage

/* sv/led_effect_frame_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_effect_frame_engine_top
// LED effect frame engine: commands and frame ticks in, color writes out.
// ----------------------------------------------------------------------------
// One request at a time. A blink frame and an ended transition need no division;
// a running transition and a pulse use the shared one-bit-a-cycle divider,
// which runs 32 steps for the pulse position (pulse only) and 32 steps for each
// of the three color channels. A set-LED request may give two results.
module led_effect_frame_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata from bit 0: first_red, first_green, first_blue, second_red,
  // second_green, second_blue, target_led, time_first, time_second, step_delay
  input  logic [111:0]  s_axis_tdata_i,
  // tuser: mode
  input  logic [3:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata from bit 0: led_index, out_red, out_green, out_blue, next_delay,
  // timer_armed, zero fill
  output logic [63:0]   m_axis_tdata_o,
  // tuser: action
  output logic [1:0]    m_axis_tuser_o,
  // tlast: last_result
  output logic          m_axis_tlast_o
);

  lefe_pkg::cmd_t cmd;
  lefe_pkg::sts_t sts;
  logic [15:0] led_index, next_delay;
  logic [23:0] colour;
  logic        timer_armed;

  lefe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lefe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (s_axis_tuser_i),
    .first_i       ({s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]}),
    .second_i      ({s_axis_tdata_i[31:24], s_axis_tdata_i[39:32], s_axis_tdata_i[47:40]}),
    .target_i      (s_axis_tdata_i[63:48]),
    .time_first_i  (s_axis_tdata_i[79:64]),
    .time_second_i (s_axis_tdata_i[95:80]),
    .step_delay_i  (s_axis_tdata_i[111:96]),
    .action_o      (m_axis_tuser_o),
    .led_index_o   (led_index),
    .colour_o      (colour),
    .next_delay_o  (next_delay),
    .timer_armed_o (timer_armed),
    .last_o        (m_axis_tlast_o)
  );

  // Pack the result
  assign m_axis_tdata_o = {7'd0, timer_armed, next_delay, colour[7:0], colour[15:8],
                           colour[23:16], led_index};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output open together");
  a_refresh_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == lefe_pkg::ACT_REFRESH) |-> m_axis_tlast_o)
    else $error("refresh result not last");
  a_armed_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[56] == 1'b0))
    else $error("timer armed on a non-final result");
`endif

endmodule

/* sv/lefe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lefe_ctrl
// Sequencer: per request, emits a command result, runs a frame or refreshes.
// ----------------------------------------------------------------------------
module lefe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lefe_pkg::sts_t sts_i,
  output lefe_pkg::cmd_t cmd_o
);

  lefe_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lefe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence and issue commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      lefe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lefe_pkg::ST_DECIDE;
        end
      end
      lefe_pkg::ST_DECIDE: begin
        if (sts_i.cmd_res) begin
          cmd_o.out_cmd = 1'b1;
          state_d       = lefe_pkg::ST_OUT_CMD;
        end else if (sts_i.frame_act) begin
          state_d = lefe_pkg::ST_MUL;
        end else begin
          cmd_o.out_idle = 1'b1;
          state_d        = lefe_pkg::ST_OUT_FIN;
        end
      end
      lefe_pkg::ST_OUT_CMD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sts_i.frame_act ? lefe_pkg::ST_MUL : lefe_pkg::ST_IDLE;
        end
      end
      lefe_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        unique case (sts_i.kind)
          lefe_pkg::KIND_PULSE: state_d = lefe_pkg::ST_MOD_GO;
          lefe_pkg::KIND_TRANS: state_d = lefe_pkg::ST_PREP;
          default:              state_d = lefe_pkg::ST_FIN;
        endcase
      end
      lefe_pkg::ST_MOD_GO: begin
        cmd_o.mod_go = 1'b1;
        state_d      = lefe_pkg::ST_MOD_WAIT;
      end
      lefe_pkg::ST_MOD_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.pos_load = 1'b1;
          state_d        = lefe_pkg::ST_PREP;
        end
      end
      lefe_pkg::ST_PREP: begin
        if (sts_i.kind == lefe_pkg::KIND_TRANS && sts_i.trans_end) begin
          state_d = lefe_pkg::ST_FIN;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = lefe_pkg::ST_CH_GO;
        end
      end
      lefe_pkg::ST_CH_GO: begin
        cmd_o.ch_go = 1'b1;
        state_d     = lefe_pkg::ST_CH_WAIT;
      end
      lefe_pkg::ST_CH_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.ch_store = 1'b1;
          state_d        = sts_i.ch_last ? lefe_pkg::ST_FIN : lefe_pkg::ST_CH_GO;
        end
      end
      lefe_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = lefe_pkg::ST_OUT_FIN;
      end
      lefe_pkg::ST_OUT_FIN: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = lefe_pkg::ST_IDLE;
        end
      end
      default: state_d = lefe_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/lefe_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lefe_dp
// Effect state, frame counter, shared divider, color mixer and result register.
// ----------------------------------------------------------------------------
module lefe_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lefe_pkg::cmd_t cmd_i,
  output lefe_pkg::sts_t sts_o,
  input  logic [3:0]     mode_i,
  input  logic [23:0]    first_i,
  input  logic [23:0]    second_i,
  input  logic [15:0]    target_i,
  input  logic [15:0]    time_first_i,
  input  logic [15:0]    time_second_i,
  input  logic [15:0]    step_delay_i,
  output logic [1:0]     action_o,
  output logic [15:0]    led_index_o,
  output logic [23:0]    colour_o,
  output logic [15:0]    next_delay_o,
  output logic           timer_armed_o,
  output logic           last_o
);

  // Effect state
  logic [3:0]  act_q;
  logic [23:0] c1_q, c2_q;
  logic [15:0] led_q, tf_q, ts_q, dly_q;
  logic [31:0] fc_q;

  // Latched request
  logic [3:0]  in_mode_q;
  logic [23:0] in_first_q;
  logic [15:0] in_led_q;

  // Frame work registers
  logic [31:0] t_q;
  logic [16:0] pos_q;
  logic [23:0] s_q, e_q, col_q;
  logic [16:0] num_q, den_q;
  logic [1:0]  ch_q;

  // Divider
  logic [31:0]             dvd_q;
  logic [16:0]             rem_q, dsr_q;
  logic                    busy_q;
  logic [lefe_pkg::DIV_CW-1:0] cnt_q;

  // Result register
  logic [1:0]  o_act_q;
  logic [15:0] o_led_q, o_dly_q;
  logic [23:0] o_col_q;
  logic        o_arm_q, o_last_q;

  logic        frame_act, one_led, even;
  logic        act_one_led, do_store;
  logic [3:0]  store_mode;
  logic [16:0] dur;
  logic [23:0] other;
  logic [17:0] rem_sh;
  logic        rem_ge;
  logic [7:0]  s8, e8, q8, r8, diff8;
  logic        bypass;
  logic [24:0] prod;
  logic [31:0] ch_dvd;
  logic [31:0] t_full;
  lefe_pkg::kind_e kind;

  // Decode the active effect
  assign frame_act = (act_q >= lefe_pkg::MODE_BLINK) && (act_q <= lefe_pkg::MODE_TRANS_ONE);
  assign one_led   = act_q >= lefe_pkg::MODE_BLINK_ONE;
  always_comb begin
    unique case (act_q) inside
      lefe_pkg::MODE_PULSE, lefe_pkg::MODE_PULSE_ONE: kind = lefe_pkg::KIND_PULSE;
      lefe_pkg::MODE_TRANS, lefe_pkg::MODE_TRANS_ONE: kind = lefe_pkg::KIND_TRANS;
      default:                                        kind = lefe_pkg::KIND_BLINK;
    endcase
  end
  assign even  = ~fc_q[0];
  assign dur   = {1'b0, tf_q} + {1'b0, ts_q};
  assign other = (act_q == lefe_pkg::MODE_PULSE) ? c2_q : 24'd0;

  // Decide what a new request stores
  assign act_one_led = (act_q >= lefe_pkg::MODE_BLINK_ONE) &&
                       (act_q <= lefe_pkg::MODE_TRANS_ONE);
  always_comb begin
    do_store   = 1'b0;
    store_mode = mode_i;
    if (mode_i == lefe_pkg::MODE_SET_ALL) begin
      do_store = 1'b1;
    end else if (mode_i == lefe_pkg::MODE_SET_LED) begin
      do_store = act_one_led && (led_q == target_i);
    end else if (mode_i >= lefe_pkg::MODE_BLINK && mode_i <= lefe_pkg::MODE_TRANS_ONE) begin
      do_store = 1'b1;
    end
  end

  // Hold the effect state and the frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= lefe_pkg::MODE_TICK;
      c1_q  <= '0;
      c2_q  <= '0;
      led_q <= '0;
      tf_q  <= '0;
      ts_q  <= '0;
      dly_q <= '0;
      fc_q  <= '0;
    end else begin
      if (cmd_i.load && do_store) begin
        act_q <= store_mode;
        c1_q  <= first_i;
        c2_q  <= second_i;
        led_q <= target_i;
        tf_q  <= time_first_i;
        ts_q  <= time_second_i;
        dly_q <= step_delay_i;
        if (mode_i >= lefe_pkg::MODE_BLINK) begin
          fc_q <= '0;
        end
      end else if (cmd_i.fin) begin
        fc_q <= fc_q + 32'd1;
      end
    end
  end

  // Divider step: one quotient bit a cycle
  assign rem_sh = {rem_q, dvd_q[31]};
  assign rem_ge = rem_sh >= {1'b0, dsr_q};

  // Channel operands
  assign s8     = lefe_pkg::chan_sel(s_q, ch_q);
  assign e8     = lefe_pkg::chan_sel(e_q, ch_q);
  assign diff8  = (e8 >= s8) ? (e8 - s8) : (s8 - e8);
  assign prod   = {17'd0, diff8} * {8'd0, num_q};
  assign ch_dvd = (e8 >= s8) ? {7'd0, prod}
                             : {7'd0, prod} + {15'd0, den_q} - 32'd1;
  assign bypass = (den_q == 17'd0) || (num_q >= den_q);
  assign q8     = dvd_q[7:0];
  assign r8     = bypass ? e8 : ((e8 >= s8) ? (s8 + q8) : (s8 - q8));
  assign t_full = fc_q * {16'd0, dly_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ch_q   <= '0;
    end else begin
      if (cmd_i.mod_go || cmd_i.ch_go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + lefe_pkg::DIV_CW'(1);
        if (cnt_q == lefe_pkg::DIV_CW'(lefe_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.prep) begin
        ch_q <= '0;
      end else if (cmd_i.ch_store) begin
        ch_q <= ch_q + 2'd1;
      end
    end
  end

  // Run the datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_mode_q  <= mode_i;
      in_first_q <= first_i;
      in_led_q   <= target_i;
    end
    if (cmd_i.mul) begin
      t_q <= t_full;
    end
    // Load or step the divider
    if (cmd_i.mod_go) begin
      dvd_q <= t_q;
      rem_q <= '0;
      dsr_q <= dur;
    end else if (cmd_i.ch_go) begin
      dvd_q <= ch_dvd;
      rem_q <= '0;
      dsr_q <= den_q;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], rem_ge};
      rem_q <= rem_ge ? 17'(rem_sh - {1'b0, dsr_q}) : rem_sh[16:0];
    end
    if (cmd_i.pos_load) begin
      pos_q <= (dur == 17'd0) ? 17'd0 : rem_q;
    end
    // Pick the interpolation end points and ratio
    if (cmd_i.prep) begin
      if (kind == lefe_pkg::KIND_PULSE) begin
        if (pos_q < {1'b0, tf_q}) begin
          s_q   <= c1_q;
          e_q   <= other;
          num_q <= pos_q;
          den_q <= {1'b0, tf_q};
        end else begin
          s_q   <= other;
          e_q   <= c1_q;
          num_q <= pos_q - {1'b0, tf_q};
          den_q <= {1'b0, ts_q};
        end
      end else begin
        s_q   <= c1_q;
        e_q   <= c2_q;
        num_q <= {1'b0, t_q[15:0]};
        den_q <= {1'b0, tf_q};
      end
    end
    if (cmd_i.ch_store) begin
      case (ch_q)
        2'd0:    col_q[23:16] <= r8;
        2'd1:    col_q[15:8]  <= r8;
        default: col_q[7:0]   <= r8;
      endcase
    end
    // Load the result register
    if (cmd_i.out_cmd) begin
      o_act_q  <= (in_mode_q == lefe_pkg::MODE_SET_ALL) ? lefe_pkg::ACT_ALL : lefe_pkg::ACT_ONE;
      o_led_q  <= (in_mode_q == lefe_pkg::MODE_SET_LED) ? in_led_q : 16'd0;
      o_col_q  <= in_first_q;
      o_dly_q  <= '0;
      o_arm_q  <= 1'b0;
      o_last_q <= ~frame_act;
    end else if (cmd_i.out_idle) begin
      o_act_q  <= lefe_pkg::ACT_REFRESH;
      o_led_q  <= '0;
      o_col_q  <= '0;
      o_dly_q  <= '0;
      o_arm_q  <= 1'b0;
      o_last_q <= 1'b1;
    end else if (cmd_i.fin) begin
      o_act_q  <= one_led ? lefe_pkg::ACT_ONE : lefe_pkg::ACT_ALL;
      o_led_q  <= one_led ? led_q : 16'd0;
      o_last_q <= 1'b1;
      case (kind)
        lefe_pkg::KIND_BLINK: begin
          o_col_q <= even ? c1_q : c2_q;
          o_dly_q <= even ? tf_q : ts_q;
          o_arm_q <= 1'b1;
        end
        lefe_pkg::KIND_PULSE: begin
          o_col_q <= col_q;
          o_dly_q <= dly_q;
          o_arm_q <= 1'b1;
        end
        default: begin
          o_col_q <= sts_o.trans_end ? c2_q : col_q;
          o_dly_q <= sts_o.trans_end ? 16'd0 : dly_q;
          o_arm_q <= ~sts_o.trans_end;
        end
      endcase
    end
  end

  // Report status
  assign sts_o.cmd_res   = (in_mode_q == lefe_pkg::MODE_SET_ALL) ||
                           (in_mode_q == lefe_pkg::MODE_SET_LED);
  assign sts_o.frame_act = frame_act;
  assign sts_o.kind      = kind;
  assign sts_o.trans_end = (tf_q == 16'd0) || (t_q >= {16'd0, tf_q});
  assign sts_o.div_busy  = busy_q;
  assign sts_o.ch_last   = ch_q == 2'd2;

  assign action_o      = o_act_q;
  assign led_index_o   = o_led_q;
  assign colour_o      = o_col_q;
  assign next_delay_o  = o_dly_q;
  assign timer_armed_o = o_arm_q;
  assign last_o        = o_last_q;

endmodule
